// ===== rtl/pwvc_pkg.sv =====
// shared types, constants and helpers for the pulse width voice command sender
// no dependencies; imported by every rtl file of the block
package pwvc_pkg;

   // frame store depth and derived widths
   localparam int FRAME_BYTES = 4;
   localparam int BYTE_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
   localparam int FULL_LEN    = (FRAME_BYTES < 4) ? FRAME_BYTES : 4;

   // frame byte codes
   localparam logic [7:0] BYTE_HEAD   = 8'h0A;
   localparam logic [7:0] BYTE_PLAY   = 8'h0B;
   localparam logic [7:0] BYTE_VOLUME = 8'h0C;
   localparam logic [7:0] BYTE_STOP   = 8'h12;
   localparam logic [7:0] VOLUME_MAX  = 8'd30;

   // register indexes and reset values
   localparam logic [7:0] REG_START_HIGH = 8'd0;
   localparam logic [7:0] REG_START_LOW  = 8'd1;
   localparam logic [7:0] REG_LONG       = 8'd2;
   localparam logic [7:0] REG_SHORT      = 8'd3;

   localparam logic [15:0] RST_START_HIGH = 16'd100;
   localparam logic [15:0] RST_START_LOW  = 16'd3200;
   localparam logic [15:0] RST_LONG       = 16'd600;
   localparam logic [15:0] RST_SHORT      = 16'd200;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_PLAY   = 2'd1,
      ACT_STOP   = 2'd2,
      ACT_VOLUME = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_TICK      = 2'd0,
      STAT_ACCEPTED  = 2'd1,
      STAT_REJ_BUSY  = 2'd2,
      STAT_REJ_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_START_HIGH = 2'd0,
      PH_START_LOW  = 2'd1,
      PH_BIT_HIGH   = 2'd2,
      PH_BIT_LOW    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic       line_level;
      logic       busy_res;
      logic [1:0] command_status;
   } rsp_type;

   typedef struct packed {
      logic [FRAME_BYTES-1:0][7:0] bytes;
      logic [LEN_W-1:0]            len;
   } frame_type;

   // a zero duration counts as one tick
   function automatic logic [15:0] dur(input logic [15:0] r);
      return (r == 16'd0) ? 16'd1 : r;
   endfunction

   // value / 10 by reciprocal multiply, exact for 8-bit values
   function automatic logic [7:0] div10(input logic [7:0] v);
      logic [15:0] prod;
      prod = 16'(v) * 16'd205;
      return {3'b000, prod[15:11]};
   endfunction

endpackage

// ===== rtl/pwvc_framer.sv =====
// command framer: builds the byte frame and its length for play, stop and volume
// depends on pwvc_pkg
module pwvc_framer import pwvc_pkg::*; (
   input  logic [1:0] action,
   input  logic [7:0] value,
   output frame_type  frame
);

   logic [7:0]      tens;
   logic [7:0]      units;
   logic [15:0]     tens_x10;
   logic [3:0][7:0] raw;

   // decimal digits of the value
   always_comb begin
      tens     = div10(value);
      tens_x10 = 16'(tens) * 16'd10;
      units    = value - tens_x10[7:0];
   end

   // full four byte frame before the store cut
   always_comb begin
      raw = '0;
      if (action == ACT_STOP) begin
         raw[0] = BYTE_STOP;
      end else begin
         raw[0] = BYTE_HEAD;
         raw[1] = tens;
         raw[2] = units;
         raw[3] = (action == ACT_PLAY) ? BYTE_PLAY : BYTE_VOLUME;
      end
   end

   // fit the frame into the store
   always_comb begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
         frame.bytes[i] = (i < 4) ? raw[2'(i)] : 8'h00;
      end
      frame.len = (action == ACT_STOP) ? LEN_W'(1) : LEN_W'(FULL_LEN);
   end

endmodule

// ===== rtl/pulse_width_voice_command_sender_core.sv =====
// pulse width voice command sender: one-wire byte frames, lsb first, idle high
// response registered, valid in the cycle after the request is taken; one request per cycle while rsp_stall is low
// the response register is freed by taking the response, so req_stall follows rsp_stall
// synchronous active high reset: line idle, not sending, registers at defaults
// depends on pwvc_pkg and pwvc_framer
module pulse_width_voice_command_sender_core import pwvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   // configuration
   logic [15:0] start_high_ff, start_low_ff, long_ff, short_ff;

   // waveform state
   logic [FRAME_BYTES-1:0][7:0] frame_bytes_ff, frame_bytes_in;
   logic [LEN_W-1:0]            frame_len_ff, frame_len_in;
   logic [BYTE_W-1:0]           byte_pos_ff, byte_pos_in;
   logic [2:0]                  bit_pos_ff, bit_pos_in;
   phase_type                   phase_ff, phase_in;
   logic [15:0]                 ticks_ff, ticks_in;
   logic                        sending_ff, sending_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic       req_fire;
   frame_type  frame;
   logic       level_now;
   logic [15:0] ticks_dec;
   logic [LEN_W-1:0] byte_next;
   logic [2:0] bit_next;
   logic       bit_sel;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pwvc_framer u_framer (
      .action (req_data.action),
      .value  (req_data.value),
      .frame  (frame)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_high_ff <= RST_START_HIGH;
         start_low_ff  <= RST_START_LOW;
         long_ff       <= RST_LONG;
         short_ff      <= RST_SHORT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_START_HIGH: start_high_ff <= csr_data;
            REG_START_LOW:  start_low_ff  <= csr_data;
            REG_LONG:       long_ff       <= csr_data;
            REG_SHORT:      short_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // line level of the segment in force
   assign level_now = ~sending_ff | (phase_ff == PH_START_HIGH) | (phase_ff == PH_BIT_HIGH);
   assign ticks_dec = (ticks_ff != 16'd0) ? ticks_ff - 16'd1 : 16'd0;
   assign byte_next = LEN_W'(byte_pos_ff) + LEN_W'(1);
   assign bit_next  = (phase_ff == PH_START_LOW) ? 3'd0 :
                      (phase_ff == PH_BIT_LOW)   ? bit_pos_ff + 3'd1 : bit_pos_ff;
   assign bit_sel   = frame_bytes_ff[byte_pos_ff][bit_next];

   // next state and response
   always_comb begin
      frame_bytes_in = frame_bytes_ff;
      frame_len_in   = frame_len_ff;
      byte_pos_in    = byte_pos_ff;
      bit_pos_in     = bit_pos_ff;
      phase_in       = phase_ff;
      ticks_in       = ticks_ff;
      sending_in     = sending_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_data_in    = rsp_data_ff;

      if (req_fire) begin
         rsp_valid_in = 1'b1;
         if (req_data.action == ACT_TICK) begin
            rsp_data_in = '{line_level: level_now, busy_res: sending_ff,
                            command_status: STAT_TICK};
            // waveform step
            if (sending_ff) begin
               ticks_in = ticks_dec;
               if (ticks_dec == 16'd0) begin
                  case (phase_ff)
                     PH_START_HIGH: begin
                        phase_in = PH_START_LOW;
                        ticks_in = dur(start_low_ff);
                     end
                     PH_START_LOW: begin
                        bit_pos_in = 3'd0;
                        phase_in   = PH_BIT_HIGH;
                        ticks_in   = dur(bit_sel ? long_ff : short_ff);
                     end
                     PH_BIT_HIGH: begin
                        phase_in = PH_BIT_LOW;
                        ticks_in = dur(bit_sel ? short_ff : long_ff);
                     end
                     default: begin
                        if (bit_pos_ff != 3'd7) begin
                           bit_pos_in = bit_next;
                           phase_in   = PH_BIT_HIGH;
                           ticks_in   = dur(bit_sel ? long_ff : short_ff);
                        end else begin
                           bit_pos_in = 3'd0;
                           phase_in   = PH_START_HIGH;
                           if (byte_next >= frame_len_ff) begin
                              sending_in  = 1'b0;
                              byte_pos_in = '0;
                              ticks_in    = 16'd0;
                           end else begin
                              byte_pos_in = byte_next[BYTE_W-1:0];
                              ticks_in    = dur(start_high_ff);
                           end
                        end
                     end
                  endcase
               end
            end
         end else if (sending_ff) begin
            rsp_data_in = '{line_level: level_now, busy_res: 1'b1,
                            command_status: STAT_REJ_BUSY};
         end else if (req_data.action == ACT_VOLUME && req_data.value > VOLUME_MAX) begin
            rsp_data_in = '{line_level: level_now, busy_res: 1'b0,
                            command_status: STAT_REJ_RANGE};
         end else begin
            // start a new frame
            frame_bytes_in = frame.bytes;
            frame_len_in   = frame.len;
            byte_pos_in    = '0;
            bit_pos_in     = 3'd0;
            phase_in       = PH_START_HIGH;
            ticks_in       = dur(start_high_ff);
            sending_in     = 1'b1;
            rsp_data_in    = '{line_level: 1'b1, busy_res: 1'b1,
                               command_status: STAT_ACCEPTED};
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff <= '0;
         byte_pos_ff  <= '0;
         bit_pos_ff   <= 3'd0;
         phase_ff     <= PH_START_HIGH;
         ticks_ff     <= 16'd0;
         sending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_len_ff <= frame_len_in;
         byte_pos_ff  <= byte_pos_in;
         bit_pos_ff   <= bit_pos_in;
         phase_ff     <= phase_in;
         ticks_ff     <= ticks_in;
         sending_ff   <= sending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      frame_bytes_ff <= frame_bytes_in;
      rsp_data_ff    <= rsp_data_in;
   end

endmodule

// ===== rtl/pwvc_checker.sv =====
// port level checks for the pulse width voice command sender, bound to the top level
// depends on pwvc_pkg and pulse_width_voice_command_sender_core
module pwvc_checker import pwvc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // an accepted command starts the frame with the line high
   a_accept_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.command_status == STAT_ACCEPTED
         |-> rsp_data.busy_res && rsp_data.line_level)
      else $error("accepted command without busy high line");

   // the line is high whenever nothing is being sent
   a_idle_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |-> rsp_data.line_level)
      else $error("line low while idle");

   // busy rejection only while busy, range rejection only while idle
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.command_status == STAT_REJ_BUSY) |-> rsp_data.busy_res)
      else $error("busy rejection while idle");

   a_reject_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.command_status == STAT_REJ_RANGE) |-> !rsp_data.busy_res)
      else $error("range rejection while busy");

endmodule

bind pulse_width_voice_command_sender_core pwvc_checker u_pwvc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== bench/line_report_checker.sv =====
// checker for the pulse width voice command sender: watches the request, response
// and register channels, predicts each line report and compares it field by field
// depends on pwvc_pkg
module line_report_checker import pwvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          failures,
   output int          reports_pending,
   output logic        frame_active
);
   timeunit 1ns;
   timeprecision 1ps;

   // timing registers as last written
   logic [15:0] lead_high_ticks;
   logic [15:0] lead_low_ticks;
   logic [15:0] long_part_ticks;
   logic [15:0] short_part_ticks;

   // waveform state
   logic [7:0]  frame_store [FRAME_BYTES];
   int unsigned frame_len;
   int unsigned build_len;
   int unsigned byte_idx;
   int unsigned bit_idx;
   phase_type   segment;
   logic [15:0] ticks_left;
   logic        sending;

   // line reports still owed by the block
   rsp_type     owed_reports [$];

   // a zero register still lasts one tick
   function automatic logic [15:0] at_least_one(input logic [15:0] r);
      return (r == 16'd0) ? 16'd1 : r;
   endfunction

   function automatic logic bit_now();
      if (byte_idx < FRAME_BYTES) begin
         return frame_store[byte_idx][bit_idx];
      end
      return 1'b0;
   endfunction

   function automatic logic line_high();
      return !sending || segment == PH_START_HIGH || segment == PH_BIT_HIGH;
   endfunction

   task automatic load_bit_high();
      segment    = PH_BIT_HIGH;
      ticks_left = at_least_one(bit_now() ? long_part_ticks : short_part_ticks);
   endtask

   // move to the segment after the one that just ran out
   task automatic next_segment();
      case (segment)
         PH_START_HIGH: begin
            segment    = PH_START_LOW;
            ticks_left = at_least_one(lead_low_ticks);
         end
         PH_START_LOW: begin
            bit_idx = 0;
            load_bit_high();
         end
         PH_BIT_HIGH: begin
            segment    = PH_BIT_LOW;
            ticks_left = at_least_one(bit_now() ? short_part_ticks : long_part_ticks);
         end
         default: begin
            if (bit_idx < 7) begin
               bit_idx++;
               load_bit_high();
            end else begin
               bit_idx = 0;
               byte_idx++;
               segment = PH_START_HIGH;
               if (byte_idx >= frame_len) begin
                  sending    = 1'b0;
                  byte_idx   = 0;
                  ticks_left = 16'd0;
               end else begin
                  ticks_left = at_least_one(lead_high_ticks);
               end
            end
         end
      endcase
   endtask

   task automatic add_byte(input logic [7:0] b);
      if (build_len < FRAME_BYTES) begin
         frame_store[build_len] = b;
      end
      build_len++;
   endtask

   // expected report for one request, advancing the waveform state
   task automatic predict_report(input req_type r, output rsp_type e);
      status_type status;
      logic       level;
      logic       busy;
      status = STAT_TICK;
      if (r.action == ACT_TICK) begin
         level = line_high();
         busy  = sending;
         if (sending) begin
            if (ticks_left > 16'd0) ticks_left--;
            if (ticks_left == 16'd0) next_segment();
         end
      end else begin
         if (sending) begin
            status = STAT_REJ_BUSY;
         end else if (r.action == ACT_VOLUME && r.value > VOLUME_MAX) begin
            status = STAT_REJ_RANGE;
         end else begin
            build_len = 0;
            if (r.action == ACT_STOP) begin
               add_byte(BYTE_STOP);
            end else begin
               add_byte(BYTE_HEAD);
               add_byte(r.value / 8'd10);
               add_byte(r.value % 8'd10);
               add_byte(r.action == ACT_PLAY ? BYTE_PLAY : BYTE_VOLUME);
            end
            frame_len  = (build_len > FRAME_BYTES) ? FRAME_BYTES : build_len;
            byte_idx   = 0;
            bit_idx    = 0;
            segment    = PH_START_HIGH;
            ticks_left = at_least_one(lead_high_ticks);
            sending    = 1'b1;
            status     = STAT_ACCEPTED;
         end
         level = line_high();
         busy  = sending;
      end
      e.line_level     = level;
      e.busy_res       = busy;
      e.command_status = status;
   endtask

   // watch all three channels on each edge
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         lead_high_ticks  = RST_START_HIGH;
         lead_low_ticks   = RST_START_LOW;
         long_part_ticks  = RST_LONG;
         short_part_ticks = RST_SHORT;
         frame_len  = 0;
         byte_idx   = 0;
         bit_idx    = 0;
         segment    = PH_START_HIGH;
         ticks_left = 16'd0;
         sending    = 1'b0;
         owed_reports.delete();
      end else begin
         // responses against the oldest owed report
         if (rsp_valid && !rsp_stall) begin
            if (owed_reports.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_data);
               failures++;
            end else begin
               want = owed_reports.pop_front();
               if (rsp_data.line_level !== want.line_level) begin
                  $error("line_level: expected %0b, got %0b",
                         want.line_level, rsp_data.line_level);
                  failures++;
               end
               if (rsp_data.busy_res !== want.busy_res) begin
                  $error("busy_res: expected %0b, got %0b",
                         want.busy_res, rsp_data.busy_res);
                  failures++;
               end
               if (rsp_data.command_status !== want.command_status) begin
                  $error("command_status: expected %0d, got %0d",
                         want.command_status, rsp_data.command_status);
                  failures++;
               end
            end
         end
         // accepted requests see the registers as they were before this edge
         if (req_valid && !req_stall) begin
            predict_report(req_data, want);
            owed_reports.push_back(want);
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_START_HIGH: lead_high_ticks  = csr_data;
               REG_START_LOW:  lead_low_ticks   = csr_data;
               REG_LONG:       long_part_ticks  = csr_data;
               REG_SHORT:      short_part_ticks = csr_data;
               default: ;
            endcase
         end
      end
      reports_pending <= owed_reports.size();
      frame_active    <= sending;
   end

endmodule

// ===== bench/testbench.sv =====
// top of the bench: clock, reset, stimulus and verdict for the voice command sender
// depends on pwvc_pkg, pulse_width_voice_command_sender_core and line_report_checker
module testbench import pwvc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERIOD      = 4;
   localparam int CYCLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [15:0] csr_data;

   int          failures;
   int          reports_pending;
   logic        frame_active;
   logic        idle_on;
   int          stall_left;
   int          cycles;

   pulse_width_voice_command_sender_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   line_report_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .failures        (failures),
      .reports_pending (reports_pending),
      .frame_active    (frame_active)
   );

   always #(PERIOD / 2) clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      if (!idle_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side stalls in random bursts
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // one request, returns at the edge that accepts it with valid still high
   task automatic send_request(input action_type act, input logic [7:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{action: act, value: val};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait until every report has come back
   task automatic wait_settled();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
   endtask

   // tick until the frame on the line is done
   task automatic finish_frame();
      wait_settled();
      while (frame_active) send_request(ACT_TICK, 8'($urandom_range(0, 255)));
      wait_settled();
   endtask

   task automatic write_register(input logic [7:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // new timing, written only with the line idle
   task automatic apply_timing(input logic [15:0] lead_high, input logic [15:0] lead_low,
                               input logic [15:0] long_part, input logic [15:0] short_part);
      finish_frame();
      repeat (3) @(posedge clock);
      write_register(REG_START_HIGH, lead_high);
      write_register(REG_START_LOW, lead_low);
      write_register(REG_LONG, long_part);
      write_register(REG_SHORT, short_part);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_command();
      action_type act;
      logic [7:0] val;
      act = action_type'($urandom_range(1, 3));
      val = 8'($urandom_range(0, 255));
      if (act == ACT_VOLUME && $urandom_range(0, 3) != 0) val = 8'($urandom_range(0, 30));
      send_request(act, val);
   endtask

   initial begin : stimulus
      int phase;
      int k;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = 8'd0;
      csr_data   = 16'd0;
      idle_on    = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset start-high time, short bits: idle ticks, a stop frame, commands while busy
      write_register(REG_START_LOW, 16'd2);
      write_register(REG_LONG, 16'd3);
      write_register(REG_SHORT, 16'd1);
      csr_valid <= 1'b0;
      send_request(ACT_TICK, 8'h00);
      send_request(ACT_TICK, 8'hFF);
      send_request(ACT_STOP, 8'hFF);
      send_request(ACT_PLAY, 8'd7);
      send_request(ACT_VOLUME, 8'd99);
      send_request(ACT_STOP, 8'h00);
      finish_frame();

      // short timing with idling: range limits, large sound numbers
      idle_on <= 1'b1;
      apply_timing(16'd1, 16'd2, 16'd2, 16'd1);
      send_request(ACT_VOLUME, 8'd31);
      send_request(ACT_VOLUME, 8'd255);
      send_request(ACT_PLAY, 8'd0);
      send_request(ACT_VOLUME, 8'd31);
      finish_frame();
      send_request(ACT_PLAY, 8'd255);
      finish_frame();
      send_request(ACT_VOLUME, 8'd30);
      finish_frame();

      // zero registers count as one tick
      apply_timing(16'd0, 16'd0, 16'd0, 16'd0);
      send_request(ACT_PLAY, 8'd170);
      finish_frame();

      // random phases with small timings
      for (phase = 0; phase < 6; phase++) begin
         idle_on <= (phase != 2);
         apply_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                      16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
         for (k = 0; k < 30; k++) begin
            if ($urandom_range(0, 99) == 0) wait_settled();
            if (frame_active) begin
               if ($urandom_range(0, 19) == 0) send_random_command();
               else send_request(ACT_TICK, 8'($urandom_range(0, 255)));
            end else begin
               if ($urandom_range(0, 9) < 6) send_random_command();
               else send_request(ACT_TICK, 8'($urandom_range(0, 255)));
            end
         end
      end

      // drain and verdict
      wait_settled();
      repeat (8) @(posedge clock);
      if (failures == 0 && reports_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
